/* src/byte_to_10b_line_encoder_packer_defines.svh */
// Assertion helpers used by the checker file.
`ifndef BYTE_TO_10B_LINE_ENCODER_PACKER_DEFINES_SVH
`define BYTE_TO_10B_LINE_ENCODER_PACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define B10P_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define B10P_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/b10p_pkg.sv */
package b10p_pkg;

	localparam int SYM_BITS = 10;

	// RD- codes of the 5b/6b group, bit a at bit 0
	localparam logic [5:0] CODE6_NEG [32] = '{
		6'h39, 6'h2E, 6'h2D, 6'h23, 6'h2B, 6'h25, 6'h26, 6'h07,
		6'h27, 6'h29, 6'h2A, 6'h0B, 6'h2C, 6'h0D, 6'h0E, 6'h3A,
		6'h36, 6'h31, 6'h32, 6'h13, 6'h34, 6'h15, 6'h16, 6'h17,
		6'h33, 6'h19, 6'h1A, 6'h1B, 6'h1C, 6'h1D, 6'h1E, 6'h35
	};

	// RD- codes of the 3b/4b group, bit f at bit 0; entry 7 is P7
	localparam logic [3:0] CODE4_NEG [8] = '{
		4'hD, 4'h9, 4'hA, 4'h3, 4'hB, 4'h5, 4'h6, 4'h7
	};

	localparam logic [3:0] CODE4_A7 = 4'hE;

	// 5b/6b input that is balanced but still flips under RD+
	localparam logic [4:0] X_FLIP6 = 5'd7;
	// 3b/4b input that is balanced but still flips under RD+
	localparam logic [2:0] Y_FLIP4 = 3'd3;
	// 3b/4b input with the A7 alternate
	localparam logic [2:0] Y_SEVEN = 3'd7;

	// last even bit position; one more symbol completes two whole bytes
	localparam logic [2:0] POS_FULL = 3'd6;

	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       two;
		logic [2:0] pos_next;
		logic [7:0] pend_next;
	} pack_res_t;

	function automatic logic [2:0] ones6(input logic [5:0] v);
		logic [2:0] n;
		n = '0;
		for (int i = 0; i < 6; i++) begin
			n = 3'(n + {2'b00, v[i]});
		end
		return n;
	endfunction

endpackage

/* src/b10p_enc.sv */
module b10p_enc (
	input  logic                          rd,
	input  logic [7:0]                    data,
	output logic [b10p_pkg::SYM_BITS-1:0] symbol,
	output logic                          rd_next
);
	import b10p_pkg::*;

	logic [4:0] x;
	logic [2:0] y;
	logic [5:0] c6;
	logic [5:0] lo;
	logic       unb6;
	logic       rd1;
	logic       alt;
	logic [3:0] c4;
	logic [3:0] hi;
	logic       unb4;

	assign x = data[4:0];
	assign y = data[7:5];

	// 5b/6b under the incoming disparity
	assign c6   = CODE6_NEG[x];
	assign unb6 = (ones6(c6) != 3'd3);
	assign lo   = (rd && (unb6 || x == X_FLIP6)) ? ~c6 : c6;
	assign rd1  = rd ^ unb6;

	// 3b/4b under the disparity left by the 6-bit group; A7 breaks a run of five
	always_comb begin
		alt = 1'b0;
		if (y == Y_SEVEN) begin
			if (rd1) begin
				alt = (x == 5'd11) || (x == 5'd13) || (x == 5'd14);
			end else begin
				alt = (x == 5'd17) || (x == 5'd18) || (x == 5'd20);
			end
		end
	end

	assign c4      = alt ? CODE4_A7 : CODE4_NEG[y];
	assign unb4    = (ones6({2'b00, c4}) != 3'd2);
	assign hi      = (rd1 && (unb4 || y == Y_FLIP4)) ? ~c4 : c4;
	assign rd_next = rd1 ^ unb4;

	assign symbol = {hi, lo};

endmodule

/* src/b10p_pack.sv */
module b10p_pack (
	input  logic [b10p_pkg::SYM_BITS-1:0] symbol,
	input  logic [2:0]                    pos,
	input  logic [7:0]                    pend,
	input  logic                          flush,
	output b10p_pkg::pack_res_t           res
);
	import b10p_pkg::*;

	logic [15:0] acc;
	logic        two;

	// pending bits above pos are zero, so OR places the symbol
	assign acc = {8'h00, pend} | ({6'b000000, symbol} << pos);
	assign two = flush || (pos == POS_FULL);

	assign res.byte0     = acc[7:0];
	assign res.byte1     = acc[15:8];
	assign res.two       = two;
	// each symbol leaves two more bits behind; wraps to zero from POS_FULL
	assign res.pos_next  = flush ? 3'd0 : 3'(pos + 3'd2);
	assign res.pend_next = two ? 8'h00 : acc[15:8];

endmodule

/* src/byte_to_10b_line_encoder_packer.sv */
// Channel | Handshake          | Payload          | Carries
// --------+--------------------+------------------+------------------------------
// in      | in_valid/in_ready  | data_byte, flush | one byte to code, flush mark
// out     | out_valid/out_ready| out_byte, last   | one packed byte, last of item
//
// A request is registered in stage 1, then coded and packed combinationally into a
// two-byte result buffer, whose entry 0 drives the port.
// The output port moves one byte a cycle while out_ready is high; an item gives
// one byte, or two bytes on flush or at bit position six.
// Reset clears disparity to negative, bit position and pending bits to zero, and
// empties both stages. A stalled output holds the buffer, then stage 1, then in_ready.
module byte_to_10b_line_encoder_packer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       flush,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last
);
	import b10p_pkg::*;

	// stage 1: accepted request
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       flush_s1;

	// coding state
	logic       rd_q;
	logic [2:0] pos_q;
	logic [7:0] pend_q;

	// result buffer, entry 0 is at the port
	logic [1:0] ob_cnt_q;
	logic [7:0] ob0_q;
	logic [7:0] ob1_q;
	logic       last0_q;
	logic       last1_q;

	logic [SYM_BITS-1:0] symbol;
	logic                rd_next;
	pack_res_t           res;
	logic                load;
	logic                pop;

	b10p_enc u_enc (
		.rd      (rd_q),
		.data    (data_s1),
		.symbol  (symbol),
		.rd_next (rd_next)
	);

	b10p_pack u_pack (
		.symbol (symbol),
		.pos    (pos_q),
		.pend   (pend_q),
		.flush  (flush_s1),
		.res    (res)
	);

	assign pop  = out_valid && out_ready;
	// move stage 1 into the buffer once it is empty or about to be
	assign load = valid_s1 && ((ob_cnt_q == 2'd0) || ((ob_cnt_q == 2'd1) && out_ready));

	assign in_ready  = !valid_s1 || load;
	assign out_valid = (ob_cnt_q != 2'd0);
	assign out_byte  = ob0_q;
	assign last      = last0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rd_q     <= 1'b0;
			pos_q    <= 3'd0;
			pend_q   <= 8'h00;
			ob_cnt_q <= 2'd0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (load) begin
				rd_q     <= rd_next;
				pos_q    <= res.pos_next;
				pend_q   <= res.pend_next;
				ob_cnt_q <= res.two ? 2'd2 : 2'd1;
			end else if (pop) begin
				ob_cnt_q <= 2'(ob_cnt_q - 2'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1  <= data_byte;
			flush_s1 <= flush;
		end
		if (load) begin
			ob0_q   <= res.byte0;
			ob1_q   <= res.byte1;
			last0_q <= !res.two;
			last1_q <= 1'b1;
		end else if (pop) begin
			// advance the second byte to the port
			ob0_q   <= ob1_q;
			last0_q <= last1_q;
		end
	end

endmodule

/* src/b10p_chk.sv */
`include "byte_to_10b_line_encoder_packer_defines.svh"

module b10p_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       last
);
	logic       in_fire;
	logic       out_fire;
	logic       done;
	logic [1:0] open_q;
	logic       mid_q;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign done     = out_fire && last;

	// track requests taken but not finished, and whether a byte pair is open
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 2'd0;
			mid_q  <= 1'b0;
		end else begin
			if (in_fire && !done) begin
				open_q <= 2'(open_q + 2'd1);
			end else if (!in_fire && done) begin
				open_q <= 2'(open_q - 2'd1);
			end
			if (out_fire) begin
				mid_q <= !last;
			end
		end
	end

	`B10P_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(out_byte) && $stable(last), "output changed while stalled")
	`B10P_ASSERT_NOW(a_no_orphan, out_valid, open_q != 2'd0, "output with no open request")
	`B10P_ASSERT_NOW(a_pair_ends, out_fire && mid_q, last, "third byte for one request")
	`B10P_ASSERT_NOW(a_depth, 1'b1, open_q != 2'd3, "more than two requests in flight")

endmodule

bind byte_to_10b_line_encoder_packer b10p_chk u_b10p_chk (.*);
